@@ sv/mf_pkg.sv @@
package mf_pkg;

    localparam int PIXEL_W       = 8;
    localparam int WIDTH_REG_W   = 8;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_WIDTH_DEF = 128;
    localparam int MIN_DIM       = 3;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_W         = 13;
    localparam int OUT_ROW_W     = 12;
    localparam int WINDOW_N      = 9;
    // rank of the median among the nine sorted window pixels
    localparam int MEDIAN_RANK   = 4;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(128);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(128);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_cfg_reg;

    typedef enum logic {
        OP_PIXEL,
        OP_PAD
    } t_op;

    // per-word position flags from the raster counters
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } t_pos_flags;

    typedef logic [WINDOW_N-1:0][PIXEL_W-1:0] t_win;

endpackage

@@ sv/mf_in_if.sv @@
interface mf_in_if;
    import mf_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);

endinterface

@@ sv/mf_out_if.sv @@
interface mf_out_if;
    import mf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

@@ sv/mf_line_store.sv @@
module mf_line_store #(
    parameter int DEPTH = mf_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [mf_pkg::PIXEL_W-1:0] i_wr_data,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [mf_pkg::PIXEL_W-1:0] o_rd_data
);
    import mf_pkg::*;

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/mf_median9.sv @@
module mf_median9 (
    input  mf_pkg::t_win               i_win,
    output logic [mf_pkg::PIXEL_W-1:0] o_med
);
    import mf_pkg::*;

    t_win p;

    function automatic logic [2*PIXEL_W-1:0] sort2(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
        // {low, high}
        return (a > b) ? {b, a} : {a, b};
    endfunction

    // 19-exchange median network; only the middle rank is valid at the end
    always_comb begin
        p = i_win;
        {p[1], p[2]} = sort2(p[1], p[2]);
        {p[4], p[5]} = sort2(p[4], p[5]);
        {p[7], p[8]} = sort2(p[7], p[8]);
        {p[0], p[1]} = sort2(p[0], p[1]);
        {p[3], p[4]} = sort2(p[3], p[4]);
        {p[6], p[7]} = sort2(p[6], p[7]);
        {p[1], p[2]} = sort2(p[1], p[2]);
        {p[4], p[5]} = sort2(p[4], p[5]);
        {p[7], p[8]} = sort2(p[7], p[8]);
        // max of mins, min of maxes, median of medians
        {p[0], p[3]} = sort2(p[0], p[3]);
        {p[5], p[8]} = sort2(p[5], p[8]);
        {p[4], p[7]} = sort2(p[4], p[7]);
        {p[3], p[6]} = sort2(p[3], p[6]);
        {p[1], p[4]} = sort2(p[1], p[4]);
        {p[2], p[5]} = sort2(p[2], p[5]);
        {p[4], p[7]} = sort2(p[4], p[7]);
        {p[2], p[4]} = sort2(p[2], p[4]);
        {p[4], p[6]} = sort2(p[4], p[6]);
        {p[2], p[4]} = sort2(p[2], p[4]);
    end

    assign o_med = p[MEDIAN_RANK];

endmodule

@@ sv/mf_position.sv @@
module mf_position #(
    parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_op,
    input  logic [mf_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic [mf_pkg::WIDTH_REG_W-1:0]  i_image_width,
    input  logic [mf_pkg::HEIGHT_REG_W-1:0] i_image_height,
    output logic [CW-1:0]                   o_addr,
    output logic [mf_pkg::PIXEL_W-1:0]      o_pix,
    output mf_pkg::t_pos_flags              o_flags
);
    import mf_pkg::*;

    localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                        $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

    logic [CW-1:0]        r_in_col,  n_in_col;
    logic [CW-1:0]        r_out_col, n_out_col;
    logic [ROW_W-1:0]     r_in_row,  n_in_row;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;

    logic [WW-1:0]    w_raw, w_eff, w_m1, in_col_inc, out_col_inc;
    logic [ROW_W-1:0] h_eff, h_m1;
    logic             emit, border, last, is_pix;
    logic             in_wrap, out_wrap, out_col_end, out_row_end;

    // effective frame size, clamped to at least MIN_DIM and to what the stores and row counters hold
    always_comb begin
        w_raw = WW'(i_image_width);
        if (w_raw < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (i_image_height < ROW_W'(MIN_DIM)) begin
            h_eff = ROW_W'(MIN_DIM);
        end else if (i_image_height > ROW_W'(HEIGHT_LIMIT)) begin
            h_eff = ROW_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = i_image_height;
        end
        w_m1 = w_eff - WW'(1);
        h_m1 = h_eff - ROW_W'(1);
    end

    always_comb begin
        in_col_inc  = WW'(r_in_col) + WW'(1);
        out_col_inc = WW'(r_out_col) + WW'(1);
        in_wrap     = in_col_inc >= w_eff;
        out_wrap    = out_col_inc >= w_eff;
        out_col_end = WW'(r_out_col) >= w_m1;
        out_row_end = ROW_W'(r_out_row) >= h_m1;
        emit        = (r_in_row >= ROW_W'(2)) ||
                      ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
        border      = (r_out_row == '0) || out_row_end ||
                      (r_out_col == '0) || out_col_end;
        last        = out_row_end && out_col_end;
        is_pix      = r_in_row < h_eff;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_adv) begin
            if (in_wrap) begin
                n_in_col = '0;
                if (r_in_row != '1) begin
                    n_in_row = r_in_row + ROW_W'(1);
                end
            end else begin
                n_in_col = CW'(in_col_inc);
            end
            if (emit) begin
                if (last) begin
                    // frame done: next word is the first pixel of a new frame
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = CW'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_addr  = r_in_col;
    assign o_pix   = (is_pix && (i_op == OP_PIXEL)) ? i_pixel : '0;
    assign o_flags = '{emit: emit, border: border, last: last};

endmodule

@@ sv/median_filter_3x3.sv @@
// 3x3 median filter over a raster-order stream of 8-bit grayscale pixels.
//
// Channels: i_in carries one word per raster position (op, pixel); op = pad
// marks a padding word, which counts as a position but carries no pixel.
// o_out carries (value, last). Both use valid/ready; a word moves on a
// rising edge with valid and ready high.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data write image_width (0) or
// image_height (1); write only while the block is idle.
// Each result belongs to the position width+1 words before the word that
// produces it, so a frame is followed by width+1 padding words. Border
// results are 0, and the final result of the frame has last set, after
// which the block starts a new frame.
// Throughput: one word per clock while the receiver keeps taking results. A
// word that produces a result passes stage 1, which holds the line store
// read; the median network then feeds the output register, which raises
// o_out.valid.
// Reset (synchronous, active low) clears the counters, window and valids;
// the line stores are not cleared and need no clearing pass.
// Receiver stall: the output register holds its word, the stage behind it
// fills, and i_in.ready drops only while both are full.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mf_in_if.sink                         i_in,
    mf_out_if.source                      o_out
);
    import mf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;

    // handshake
    logic accept, s1_move, out_free;

    // position counters
    logic [CW-1:0]      pos_addr;
    logic [PIXEL_W-1:0] pos_pix;
    t_pos_flags         pos_flags;

    // stage 1: word waiting for its line store data
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_pix;
    t_pos_flags         r_s1_flags;
    logic [CW-1:0]      r_s1_addr;
    logic               r_s1_fwd;

    // line store read data and the values after bypass
    logic [PIXEL_W-1:0] up_q, lo_q, up, lo;

    // registered window columns: [0..2] older, [3..5] newer (top to bottom)
    logic [PIXEL_W-1:0] r_win [6];
    t_win               window;
    logic [PIXEL_W-1:0] med;

    // output register
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_value;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept   = i_in.valid && i_in.ready;

    mf_position #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (accept),
        .i_op           (i_in.op),
        .i_pixel        (i_in.pixel),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_addr         (pos_addr),
        .o_pix          (pos_pix),
        .o_flags        (pos_flags)
    );

    // Upper store keeps the line two above, lower the line just above.
    // Both are read on acceptance and written as the word leaves stage 1.
    mf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk     (i_clk),
        .i_we      (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (lo),
        .i_re      (accept),
        .i_rd_addr (pos_addr),
        .o_rd_data (up_q)
    );

    mf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store_lower (
        .i_clk     (i_clk),
        .i_we      (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_pix),
        .i_re      (accept),
        .i_rd_addr (pos_addr),
        .o_rd_data (lo_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read and write of the same column in one cycle return stale data;
    // the word being written then sits in the newest window column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= pos_pix;
            r_s1_flags <= pos_flags;
            r_s1_addr  <= pos_addr;
            r_s1_fwd   <= s1_move && (r_s1_addr == pos_addr);
        end
    end

    assign up = r_s1_fwd ? r_win[4] : up_q;
    assign lo = r_s1_fwd ? r_win[5] : lo_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_move) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up;
            r_win[4] <= lo;
            r_win[5] <= r_s1_pix;
        end
    end

    assign window = {r_win[0], r_win[3], up,
                     r_win[1], r_win[4], lo,
                     r_win[2], r_win[5], r_s1_pix};

    mf_median9 u_median9 (
        .i_win (window),
        .o_med (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_flags.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_flags.emit) begin
            r_out_value <= r_s1_flags.border ? '0 : med;
            r_out_last  <= r_s1_flags.last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.last  = r_out_last;

endmodule

@@ sv/mf_checker.sv @@
module mf_prop_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mf_pkg::PIXEL_W-1:0] i_out_value,
    input logic                       i_out_last
);
    import mf_pkg::*;

    // a result word waiting on the receiver keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_last))
        else $error("result word changed while stalled");

    // frame end is always a border position
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_value == '0)
        else $error("last word of frame not zero");

    // input back-pressure only comes from a stalled output
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind median_filter_3x3 mf_prop_checker u_mf_prop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last)
);
